// File: rtl/cfobm_pkg.sv
// ----------------------------------------------------------------------------
// cfobm_pkg: shared definitions for the best-move unit
// Site and weight sizing, level limits and the request action codes.
// ----------------------------------------------------------------------------
package cfobm_pkg;

  // Storage sizing
  localparam int SITES       = 64;
  localparam int SITE_W      = 6;    // bits of a site index
  localparam int CNT_W       = 7;    // bits of a site count (0..SITES)
  localparam int WEIGHT_BITS = 16;
  localparam int LEVEL_W     = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 2'd0;
  localparam logic [CNT_W-1:0]   ACTIVE_RESET = 7'd64;

  // Request actions
  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_PROPOSE = 2'd1,
    ACT_ACCEPT  = 2'd2,
    ACT_REJECT  = 2'd3
  } action_t;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

endpackage

// File: rtl/close_first_open_best_move_unit.sv
// ----------------------------------------------------------------------------
// close_first_open_best_move_unit: local-search move generator
// Keeps a level (0..3) and a signed weight per site; proposes, accepts and
// rejects single-unit level moves from the first nonzero site to the best one.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the out_ ports for exactly one cycle, flagged by out_valid, and must be
// captured then. Every request gives one result. A propose runs a scan,
// which reads one site per cycle from the level and weight memories through
// a single shared compare unit. busy stays high until the result shows.
// There is no clearing pass after reset: weights use per-site valid bits.
module close_first_open_best_move_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_action,
  input  logic [cfobm_pkg::SITE_W-1:0]         in_site_index,
  input  logic [cfobm_pkg::LEVEL_W-1:0]        in_level_value,
  // result channel
  output logic                                 out_valid,
  output logic                                 out_move_found,
  output logic [cfobm_pkg::SITE_W-1:0]         out_close_site,
  output logic [cfobm_pkg::SITE_W-1:0]         out_open_site,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfobm_pkg::CNT_W-1:0]          cfg_active_sites
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LOAD   = 11'b000_0000_0010,
    S_SCAN   = 11'b000_0000_0100,
    S_MOVE_C = 11'b000_0000_1000,
    S_MOVE_O = 11'b000_0001_0000,
    S_RD_O   = 11'b000_0010_0000,
    S_WR_O   = 11'b000_0100_0000,
    S_RD_C   = 11'b000_1000_0000,
    S_WR_C   = 11'b001_0000_0000,
    S_RD_L   = 11'b010_0000_0000,
    S_WR_L   = 11'b100_0000_0000
  } state_t;

  // saturating +/-1 on a signed weight
  function automatic cfobm_pkg::weight_t bump(input cfobm_pkg::weight_t w, input logic up);
    cfobm_pkg::weight_t wmax;
    cfobm_pkg::weight_t wmin;
    cfobm_pkg::weight_t res;
    wmax = {1'b0, {(cfobm_pkg::WEIGHT_BITS-1){1'b1}}};
    wmin = {1'b1, {(cfobm_pkg::WEIGHT_BITS-1){1'b0}}};
    res  = w;
    if (up) begin
      if (w != wmax) res = w + cfobm_pkg::weight_t'(1);
    end else begin
      if (w != wmin) res = w - cfobm_pkg::weight_t'(1);
    end
    return res;
  endfunction

  state_t                          state_r, state_nxt;
  cfobm_pkg::action_t              act_r, act_nxt;
  logic [cfobm_pkg::SITE_W-1:0]    site_r, site_nxt;
  logic [cfobm_pkg::LEVEL_W-1:0]   lvl_in_r, lvl_in_nxt;
  logic [cfobm_pkg::CNT_W-1:0]     active_r, active_nxt;

  // scan state
  logic [cfobm_pkg::CNT_W-1:0]     scan_r, scan_nxt;
  logic                            pend_r, pend_nxt;
  logic [cfobm_pkg::SITE_W-1:0]    pidx_r, pidx_nxt;
  logic                            cfound_r, cfound_nxt;
  logic                            have_r, have_nxt;
  logic [cfobm_pkg::SITE_W-1:0]    close_r, close_nxt;
  logic [cfobm_pkg::SITE_W-1:0]    open_r, open_nxt;
  logic [cfobm_pkg::LEVEL_W-1:0]   close_lvl_r, close_lvl_nxt;
  logic [cfobm_pkg::LEVEL_W-1:0]   open_lvl_r, open_lvl_nxt;
  cfobm_pkg::weight_t              best_w_r, best_w_nxt;

  // move history and result
  logic [cfobm_pkg::SITE_W-1:0]    last_close_r, last_close_nxt;
  logic [cfobm_pkg::SITE_W-1:0]    last_open_r, last_open_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;

  // weight valid bits, one per site
  logic [cfobm_pkg::SITES-1:0]     wvld_r, wvld_nxt;
  logic                            wvld_d_r;

  // memory ports
  logic [cfobm_pkg::SITE_W-1:0]    rd_addr;
  logic                            lvl_we;
  logic [cfobm_pkg::SITE_W-1:0]    lvl_waddr;
  logic [cfobm_pkg::LEVEL_W-1:0]   lvl_wdata;
  logic [cfobm_pkg::LEVEL_W-1:0]   lvl_rdata;
  logic                            w_we;
  logic [cfobm_pkg::SITE_W-1:0]    w_waddr;
  cfobm_pkg::weight_t              w_wdata;
  logic [cfobm_pkg::WEIGHT_BITS-1:0] w_rdata_raw;
  cfobm_pkg::weight_t              w_eff;

  logic [cfobm_pkg::CNT_W-1:0]     scan_len;
  logic                            req_ok;

  assign busy           = (state_r != S_IDLE);
  assign req_ok         = start && !busy;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_move_found = out_found_r;
  assign out_close_site = last_close_r;
  assign out_open_site  = last_open_r;

  // scan length is min(active_sites, SITES)
  assign scan_len = (active_r > cfobm_pkg::CNT_W'(cfobm_pkg::SITES)) ?
                    cfobm_pkg::CNT_W'(cfobm_pkg::SITES) : active_r;

  // never-written weights read as zero
  assign w_eff = wvld_d_r ? cfobm_pkg::weight_t'(w_rdata_raw) : '0;

  // level and weight memories
  cfobm_ram #(
    .WIDTH (cfobm_pkg::LEVEL_W),
    .DEPTH (cfobm_pkg::SITES)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (rd_addr),
    .rdata (lvl_rdata)
  );

  cfobm_ram #(
    .WIDTH (cfobm_pkg::WEIGHT_BITS),
    .DEPTH (cfobm_pkg::SITES)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (rd_addr),
    .rdata (w_rdata_raw)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    site_nxt       = site_r;
    lvl_in_nxt     = lvl_in_r;
    active_nxt     = active_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    cfound_nxt     = cfound_r;
    have_nxt       = have_r;
    close_nxt      = close_r;
    open_nxt       = open_r;
    close_lvl_nxt  = close_lvl_r;
    open_lvl_nxt   = open_lvl_r;
    best_w_nxt     = best_w_r;
    last_close_nxt = last_close_r;
    last_open_nxt  = last_open_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = 1'b0;
    wvld_nxt       = wvld_r;
    rd_addr        = '0;
    lvl_we         = 1'b0;
    lvl_waddr      = '0;
    lvl_wdata      = '0;
    w_we           = 1'b0;
    w_waddr        = '0;
    w_wdata        = '0;

    if (cfg_valid && cfg_ready) begin
      active_nxt = cfg_active_sites;
    end

    case (state_r)
      S_IDLE: begin
        if (req_ok) begin
          act_nxt    = cfobm_pkg::action_t'(in_action);
          site_nxt   = in_site_index;
          lvl_in_nxt = in_level_value;
          scan_nxt   = '0;
          pend_nxt   = 1'b0;
          cfound_nxt = 1'b0;
          have_nxt   = 1'b0;
          case (cfobm_pkg::action_t'(in_action))
            cfobm_pkg::ACT_LOAD:    state_nxt = S_LOAD;
            cfobm_pkg::ACT_PROPOSE: state_nxt = S_SCAN;
            default:                state_nxt = S_RD_O;
          endcase
        end
      end

      S_LOAD: begin
        lvl_we        = 1'b1;
        lvl_waddr     = site_r;
        lvl_wdata     = lvl_in_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // one site read issued per cycle; its data is evaluated in the next cycle
      S_SCAN: begin
        rd_addr = scan_r[cfobm_pkg::SITE_W-1:0];
        if (scan_r < scan_len) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[cfobm_pkg::SITE_W-1:0];
          scan_nxt = scan_r + cfobm_pkg::CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (!cfound_r) begin
            if (lvl_rdata != cfobm_pkg::LEVEL_MIN) begin
              cfound_nxt    = 1'b1;
              close_nxt     = pidx_r;
              close_lvl_nxt = lvl_rdata;
            end
          end else if (lvl_rdata < cfobm_pkg::LEVEL_MAX &&
                       (!have_r || w_eff > best_w_r)) begin
            have_nxt     = 1'b1;
            best_w_nxt   = w_eff;
            open_nxt     = pidx_r;
            open_lvl_nxt = lvl_rdata;
          end
        end else if (scan_r >= scan_len) begin
          if (cfound_r && have_r) begin
            state_nxt = S_MOVE_C;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_MOVE_C: begin
        lvl_we    = 1'b1;
        lvl_waddr = close_r;
        lvl_wdata = close_lvl_r - cfobm_pkg::LEVEL_W'(1);
        state_nxt = S_MOVE_O;
      end

      S_MOVE_O: begin
        lvl_we         = 1'b1;
        lvl_waddr      = open_r;
        lvl_wdata      = open_lvl_r + cfobm_pkg::LEVEL_W'(1);
        last_close_nxt = close_r;
        last_open_nxt  = open_r;
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      // accept / reject: open weight first
      S_RD_O: begin
        rd_addr   = last_open_r;
        state_nxt = S_WR_O;
      end

      S_WR_O: begin
        w_we                  = 1'b1;
        w_waddr               = last_open_r;
        w_wdata               = bump(w_eff, act_r == cfobm_pkg::ACT_ACCEPT);
        wvld_nxt[last_open_r] = 1'b1;
        state_nxt             = S_RD_C;
      end

      S_RD_C: begin
        rd_addr   = last_close_r;
        state_nxt = S_WR_C;
      end

      // close weight, and on reject the close level rises
      S_WR_C: begin
        w_we                   = 1'b1;
        w_waddr                = last_close_r;
        w_wdata                = bump(w_eff, act_r == cfobm_pkg::ACT_ACCEPT);
        wvld_nxt[last_close_r] = 1'b1;
        if (act_r == cfobm_pkg::ACT_REJECT) begin
          lvl_we    = (lvl_rdata != cfobm_pkg::LEVEL_MAX);
          lvl_waddr = last_close_r;
          lvl_wdata = lvl_rdata + cfobm_pkg::LEVEL_W'(1);
          state_nxt = S_RD_L;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // reject: open level falls, re-read after the close write
      S_RD_L: begin
        rd_addr   = last_open_r;
        state_nxt = S_WR_L;
      end

      S_WR_L: begin
        lvl_we        = (lvl_rdata != cfobm_pkg::LEVEL_MIN);
        lvl_waddr     = last_open_r;
        lvl_wdata     = lvl_rdata - cfobm_pkg::LEVEL_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= cfobm_pkg::ACTIVE_RESET;
      last_close_r <= '0;
      last_open_r  <= '0;
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      wvld_r       <= '0;
      pend_r       <= 1'b0;
      cfound_r     <= 1'b0;
      have_r       <= 1'b0;
      scan_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      last_close_r <= last_close_nxt;
      last_open_r  <= last_open_nxt;
      out_valid_r  <= out_valid_nxt;
      out_found_r  <= out_found_nxt;
      wvld_r       <= wvld_nxt;
      pend_r       <= pend_nxt;
      cfound_r     <= cfound_nxt;
      have_r       <= have_nxt;
      scan_r       <= scan_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    site_r      <= site_nxt;
    lvl_in_r    <= lvl_in_nxt;
    pidx_r      <= pidx_nxt;
    close_r     <= close_nxt;
    open_r      <= open_nxt;
    close_lvl_r <= close_lvl_nxt;
    open_lvl_r  <= open_lvl_nxt;
    best_w_r    <= best_w_nxt;
    wvld_d_r    <= wvld_r[rd_addr];
  end

  // checks
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_found_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_move_found |-> out_valid)
    else $error("move_found without result strobe");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// File: rtl/cfobm_ram.sv
// ----------------------------------------------------------------------------
// cfobm_ram: generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cfobm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for close_first_open_best_move_unit
// Drives load, propose, accept and reject requests with random idle gaps and
// checks every result against a cycle-free mirror of the site levels,
// weights and the last move pair kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

  // One expected result
  typedef struct packed {
    logic                         found;
    logic [cfobm_pkg::SITE_W-1:0] close_site;
    logic [cfobm_pkg::SITE_W-1:0] open_site;
  } move_report_t;

  localparam cfobm_pkg::weight_t WEIGHT_TOP    = {1'b0, {(cfobm_pkg::WEIGHT_BITS-1){1'b1}}};
  localparam cfobm_pkg::weight_t WEIGHT_BOTTOM = {1'b1, {(cfobm_pkg::WEIGHT_BITS-1){1'b0}}};
  // depth of the expected-result ring
  localparam int                 REPORT_DEPTH  = 8;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [1:0]                        in_action;
  logic [cfobm_pkg::SITE_W-1:0]      in_site_index;
  logic [cfobm_pkg::LEVEL_W-1:0]     in_level_value;
  logic                              out_valid;
  logic                              out_move_found;
  logic [cfobm_pkg::SITE_W-1:0]      out_close_site;
  logic [cfobm_pkg::SITE_W-1:0]      out_open_site;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [cfobm_pkg::CNT_W-1:0]       cfg_active_sites;

  // Mirror of the block state
  logic [cfobm_pkg::LEVEL_W-1:0]     lvl_mirror [cfobm_pkg::SITES];
  cfobm_pkg::weight_t                wgt_mirror [cfobm_pkg::SITES];
  logic [cfobm_pkg::SITE_W-1:0]      prev_close;
  logic [cfobm_pkg::SITE_W-1:0]      prev_open;
  logic [cfobm_pkg::CNT_W-1:0]       scan_limit;

  // Expected results: written by the sender, read by the checker
  move_report_t                      report_ring [REPORT_DEPTH];
  int                                report_wr;
  int                                report_rd;
  int                                mismatches;

  close_first_open_best_move_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_site_index    (in_site_index),
    .in_level_value   (in_level_value),
    .out_valid        (out_valid),
    .out_move_found   (out_move_found),
    .out_close_site   (out_close_site),
    .out_open_site    (out_open_site),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_sites (cfg_active_sites)
  );

  always #5 clk = ~clk;

  // Saturating weight step
  function automatic void nudge_weight(logic [cfobm_pkg::SITE_W-1:0] site, bit up);
    if (up) begin
      if (wgt_mirror[site] != WEIGHT_TOP)
        wgt_mirror[site] = wgt_mirror[site] + cfobm_pkg::weight_t'(1);
    end else begin
      if (wgt_mirror[site] != WEIGHT_BOTTOM)
        wgt_mirror[site] = wgt_mirror[site] - cfobm_pkg::weight_t'(1);
    end
  endfunction

  // Close the first site above level 0, open the heaviest later site below full
  function automatic logic pick_move();
    int                 n;
    int                 c;
    int                 j;
    int                 best;
    bit                 have;
    cfobm_pkg::weight_t best_w;
    n    = (scan_limit > cfobm_pkg::SITES) ? cfobm_pkg::SITES : int'(scan_limit);
    c    = 0;
    have = 0;
    best = 0;
    best_w = '0;
    while (c < n && lvl_mirror[c] == cfobm_pkg::LEVEL_MIN) c++;
    if (c >= n) return 1'b0;
    for (j = c + 1; j < n; j++) begin
      if (lvl_mirror[j] < cfobm_pkg::LEVEL_MAX && (!have || wgt_mirror[j] > best_w)) begin
        have   = 1;
        best_w = wgt_mirror[j];
        best   = j;
      end
    end
    if (!have) return 1'b0;
    prev_close = cfobm_pkg::SITE_W'(c);
    prev_open  = cfobm_pkg::SITE_W'(best);
    lvl_mirror[c]    = lvl_mirror[c] - cfobm_pkg::LEVEL_W'(1);
    lvl_mirror[best] = lvl_mirror[best] + cfobm_pkg::LEVEL_W'(1);
    return 1'b1;
  endfunction

  // Advance the mirror by one request and return its result
  function automatic move_report_t predict_request(cfobm_pkg::action_t act,
                                                   logic [cfobm_pkg::SITE_W-1:0] idx,
                                                   logic [cfobm_pkg::LEVEL_W-1:0] lvl);
    move_report_t r;
    r.found = 1'b0;
    case (act)
      cfobm_pkg::ACT_LOAD: begin
        lvl_mirror[idx] = lvl;
      end
      cfobm_pkg::ACT_PROPOSE: begin
        r.found = pick_move();
      end
      cfobm_pkg::ACT_ACCEPT: begin
        nudge_weight(prev_open, 1'b1);
        nudge_weight(prev_close, 1'b1);
      end
      cfobm_pkg::ACT_REJECT: begin
        nudge_weight(prev_open, 1'b0);
        nudge_weight(prev_close, 1'b0);
        if (lvl_mirror[prev_close] < cfobm_pkg::LEVEL_MAX)
          lvl_mirror[prev_close] = lvl_mirror[prev_close] + cfobm_pkg::LEVEL_W'(1);
        if (lvl_mirror[prev_open] > cfobm_pkg::LEVEL_MIN)
          lvl_mirror[prev_open] = lvl_mirror[prev_open] - cfobm_pkg::LEVEL_W'(1);
      end
      default: begin
      end
    endcase
    r.close_site = prev_close;
    r.open_site  = prev_open;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request; start stays high when no gap follows
  task automatic send_request(cfobm_pkg::action_t act, logic [cfobm_pkg::SITE_W-1:0] idx,
                              logic [cfobm_pkg::LEVEL_W-1:0] lvl, int gap);
    start          <= 1'b1;
    in_action      <= act;
    in_site_index  <= idx;
    in_level_value <= lvl;
    do @(posedge clk); while (busy);
    report_ring[report_wr % REPORT_DEPTH] = predict_request(act, idx, lvl);
    report_wr++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every pending result has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (report_wr != report_rd || busy);
  endtask

  // Register write, only with the block idle
  task automatic set_active_sites(logic [cfobm_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg_active_sites <= value;
    cfg_valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    scan_limit = value;
  endtask

  // Result checker
  always @(posedge clk) begin
    move_report_t exp_r;
    if (rst_n && out_valid) begin
      if (report_wr == report_rd) begin
        $error("result with no pending request");
        mismatches++;
      end else begin
        exp_r = report_ring[report_rd % REPORT_DEPTH];
        report_rd++;
        if (out_move_found !== exp_r.found) begin
          $error("move_found: expected %0d, actual %0d", exp_r.found, out_move_found);
          mismatches++;
        end
        if (out_close_site !== exp_r.close_site) begin
          $error("close_site: expected %0d, actual %0d", exp_r.close_site, out_close_site);
          mismatches++;
        end
        if (out_open_site !== exp_r.open_site) begin
          $error("open_site: expected %0d, actual %0d", exp_r.open_site, out_open_site);
          mismatches++;
        end
      end
    end
  end

  // Every site gets a level before anything reads one
  task automatic test_level_fill();
    int s;
    for (s = 0; s < cfobm_pkg::SITES; s++)
      send_request(cfobm_pkg::ACT_LOAD, cfobm_pkg::SITE_W'(s),
                   cfobm_pkg::LEVEL_W'($urandom), pick_gap(0));
  endtask

  // Site 0 paired with itself: swing its weight down and back up
  task automatic test_weight_swing();
    int k;
    set_active_sites(cfobm_pkg::ACTIVE_RESET);
    for (k = 0; k < 60; k++)
      send_request(cfobm_pkg::ACT_REJECT, '0, '0, 0);
    for (k = 0; k < 120; k++)
      send_request(cfobm_pkg::ACT_ACCEPT, '0, '0, 0);
    wait_idle();
  endtask

  // Short directed cases, mostly on a four-site window
  task automatic test_directed_cases();
    int s;
    set_active_sites(7'd4);
    // nothing to close
    for (s = 0; s < 4; s++)
      send_request(cfobm_pkg::ACT_LOAD, cfobm_pkg::SITE_W'(s), cfobm_pkg::LEVEL_MIN, 1);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    // close found, every later site full
    send_request(cfobm_pkg::ACT_LOAD, 6'd1, 2'd1, 0);
    send_request(cfobm_pkg::ACT_LOAD, 6'd2, cfobm_pkg::LEVEL_MAX, 0);
    send_request(cfobm_pkg::ACT_LOAD, 6'd3, cfobm_pkg::LEVEL_MAX, 0);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 2);
    // equal weights: first open candidate wins
    send_request(cfobm_pkg::ACT_LOAD, 6'd2, cfobm_pkg::LEVEL_MIN, 0);
    send_request(cfobm_pkg::ACT_LOAD, 6'd3, cfobm_pkg::LEVEL_MIN, 0);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    send_request(cfobm_pkg::ACT_ACCEPT, '0, '0, 0);
    // move then undo
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    send_request(cfobm_pkg::ACT_REJECT, '0, '0, 0);
    // loads after the move push the undo against the level bounds
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    send_request(cfobm_pkg::ACT_LOAD, 6'd2, cfobm_pkg::LEVEL_MAX, 0);
    send_request(cfobm_pkg::ACT_LOAD, 6'd3, cfobm_pkg::LEVEL_MIN, 0);
    send_request(cfobm_pkg::ACT_REJECT, '0, '0, 0);
    // one site, zero sites: no move possible
    set_active_sites(7'd1);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    set_active_sites(7'd0);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    // count beyond the array scans every site
    set_active_sites(7'd127);
    send_request(cfobm_pkg::ACT_LOAD, 6'd63, cfobm_pkg::LEVEL_MAX, 0);
    send_request(cfobm_pkg::ACT_PROPOSE, '0, '0, 0);
    wait_idle();
  endtask

  // Random request mix at one window size
  task automatic run_random_phase(int count);
    int                           k;
    int                           r;
    int                           span;
    bit                           calm;
    cfobm_pkg::action_t           act;
    logic [cfobm_pkg::SITE_W-1:0] idx;
    calm = 0;
    span = (scan_limit == 0) ? 1 :
           ((scan_limit > cfobm_pkg::SITES) ? cfobm_pkg::SITES : int'(scan_limit));
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) wait_idle();
      r   = $urandom_range(0, 99);
      idx = ($urandom_range(0, 3) == 0) ? cfobm_pkg::SITE_W'($urandom)
                                        : cfobm_pkg::SITE_W'($urandom_range(0, span - 1));
      if (r < 25)      act = cfobm_pkg::ACT_LOAD;
      else if (r < 65) act = cfobm_pkg::ACT_PROPOSE;
      else if (r < 82) act = cfobm_pkg::ACT_ACCEPT;
      else             act = cfobm_pkg::ACT_REJECT;
      send_request(act, idx, cfobm_pkg::LEVEL_W'($urandom), pick_gap(calm));
    end
  endtask

  task automatic test_random_moves();
    set_active_sites(cfobm_pkg::ACTIVE_RESET);
    run_random_phase(250);
    set_active_sites(cfobm_pkg::CNT_W'($urandom_range(1, cfobm_pkg::SITES)));
    run_random_phase(200);
    set_active_sites(7'd127);
    run_random_phase(200);
    set_active_sites(7'd3);
    run_random_phase(150);
    set_active_sites(cfobm_pkg::CNT_W'($urandom_range(2, 16)));
    run_random_phase(200);
    set_active_sites(cfobm_pkg::ACTIVE_RESET);
    run_random_phase(200);
    wait_idle();
  endtask

  // Run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int s;
    clk              = 1'b0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_action        = cfobm_pkg::ACT_LOAD;
    in_site_index    = '0;
    in_level_value   = '0;
    cfg_valid        = 1'b0;
    cfg_active_sites = cfobm_pkg::ACTIVE_RESET;
    mismatches       = 0;
    report_wr        = 0;
    report_rd        = 0;
    for (s = 0; s < cfobm_pkg::SITES; s++) begin
      lvl_mirror[s] = cfobm_pkg::LEVEL_MIN;
      wgt_mirror[s] = '0;
    end
    prev_close = '0;
    prev_open  = '0;
    scan_limit = cfobm_pkg::ACTIVE_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_level_fill();
    test_weight_swing();
    test_directed_cases();
    test_random_moves();

    // drain tail
    wait_idle();
    repeat (20) @(posedge clk);
    if (report_wr != report_rd) begin
      $error("%0d results never arrived", report_wr - report_rd);
      mismatches++;
    end
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/cfobm_pkg.sv
rtl/cfobm_ram.sv
rtl/close_first_open_best_move_unit.sv
dv/testbench.sv
